// ===== sv/mcrbs_pkg.sv =====
// Package with payload types, command codes and constants of the mask color statistics core.
package mcrbs_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int DIM_BITS_DEF    = 12;
    localparam int REG_BITS        = 13;
    localparam int COUNT_BITS      = 25;
    localparam int FRAC_BITS       = 17;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_FRAME = 2'd3;

    localparam logic [1:0] ST_BLACK    = 2'd0;
    localparam logic [1:0] ST_RESTORED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;

    localparam logic [31:0] BLACK_PIXEL = 32'hFF00_0000;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  entry_index;
        logic [31:0] key_color;
        logic [31:0] orig_color;
        logic        entry_kind;
        logic [31:0] pixel_color;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic [1:0]  pixel_status;
        logic        entry_seen;
        logic        kind_out;
        logic [24:0] pixel_count;
        logic [11:0] min_col;
        logic [11:0] min_row;
        logic [11:0] max_col;
        logic [11:0] max_row;
        logic [16:0] area_fraction;
    } out_item_t;

endpackage

// ===== sv/mcrbs_divider.sv =====
// Restoring divider that forms the rounded, saturated area fraction one quotient bit a cycle.
module mcrbs_divider import mcrbs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [27:0]           total,
    output logic                  done,
    output logic [FRAC_BITS-1:0]  frac
);
    // Numerator is count*65536 + total/2, at most 42 bits.
    localparam int NUM_BITS = 42;

    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [27:0]         rem_reg, rem_next;
    logic [27:0]         den_reg, den_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [28:0]         trial;
    logic [28:0]         sub;

    always_comb begin
        trial = {rem_reg, num_reg[NUM_BITS-1]};
        sub = trial - {1'b0, den_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = {1'b0, count, 16'd0} + {15'd0, total[27:1]};
            rem_next = '0;
            den_next = total;
            quo_next = '0;
            cnt_next = 6'(NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_BITS-2:0], 1'b0};
            if (!sub[28]) begin
                rem_next = sub[27:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[27:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign frac = (quo_reg > 42'd65536) ? 17'd65536 : quo_reg[FRAC_BITS-1:0];
endmodule

// ===== sv/mask_color_restore_bbox_stats_core.sv =====
// Top level of the mask color restore core with per-entry bounding box and area statistics.
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     in_item_t s_data
//  m_        out        m_valid / m_ready     out_item_t m_data
//  apb       in         psel/penable/pwrite   image_width, image_height
//
// A load goes from idle straight to the output; a new-frame command first runs the pass that
// clears the pixel counts one entry a cycle; a pixel runs the key search that compares one
// table entry a cycle, then settles the status and updates the entry; a stats read waits on
// the one-bit-a-cycle area divider. After reset a clearing pass over all TABLE_DEPTH entries
// runs before the first transfer is taken. The block holds one item at a time; while a result
// waits on m_ready the next input is not accepted.
module mask_color_restore_bbox_stats_core import mcrbs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int DIM_BITS = DIM_BITS_DEF;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [DIM_BITS:0] DIM_MAX = (DIM_BITS+1)'(1) << DIM_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [REG_BITS-1:0] width_reg, height_reg;
    in_item_t item_reg;
    out_item_t res_reg;
    logic [IW:0] ptr_reg;
    logic hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [DIM_BITS-1:0] col_reg, row_reg;

    logic [31:0] key_mem [TABLE_DEPTH];
    logic [31:0] orig_mem [TABLE_DEPTH];
    logic        kind_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] count_mem [TABLE_DEPTH];
    logic [4*DIM_BITS-1:0] box_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg, seen_reg;

    logic [31:0] key_q, orig_q;
    logic kind_q;
    logic [COUNT_BITS-1:0] count_q;
    logic [4*DIM_BITS-1:0] box_q;

    logic [DIM_BITS:0] w_eff, h_eff;
    logic [27:0] total;
    logic div_start, div_done;
    logic [FRAC_BITS-1:0] frac;
    logic [IW-1:0] rd_addr;
    logic idx_in;
    logic [DIM_BITS-1:0] bmnc, bmnr, bmxc, bmxr;

    assign pready = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data = res_reg;

    always_comb begin
        w_eff = (width_reg == '0) ? (DIM_BITS+1)'(1) :
                ({1'b0, width_reg} > 14'(DIM_MAX)) ? DIM_MAX : width_reg[DIM_BITS:0];
        h_eff = (height_reg == '0) ? (DIM_BITS+1)'(1) :
                ({1'b0, height_reg} > 14'(DIM_MAX)) ? DIM_MAX : height_reg[DIM_BITS:0];
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH[0]:  prdata = {19'd0, width_reg};
            default:       prdata = {19'd0, height_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == {REG_WIDTH[0], 2'b00}) width_reg <= pwdata[REG_BITS-1:0];
            else if (paddr == {REG_HEIGHT[0], 2'b00}) height_reg <= pwdata[REG_BITS-1:0];
        end
    end

    assign idx_in = ({1'b0, item_reg.entry_index} < 7'(TABLE_DEPTH));
    assign rd_addr = (state_reg == S_SRCH) ? ptr_reg[IW-1:0] :
                     (state_reg == S_IDLE) ? s_data.entry_index[IW-1:0] : hit_idx_reg;

    always_ff @(posedge aclk) begin
        key_q <= key_mem[rd_addr];
        orig_q <= orig_mem[rd_addr];
        kind_q <= kind_mem[rd_addr];
        count_q <= count_mem[rd_addr];
        box_q <= box_mem[rd_addr];
    end

    assign {bmnc, bmnr, bmxc, bmxr} = box_q;
    assign total = 28'(w_eff) * 28'(h_eff);
    assign div_start = (state_reg == S_RD);

    mcrbs_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .count(count_q),
        .total(total), .done(div_done), .frac(frac)
    );

    logic [IW-1:0] p_d;
    always_ff @(posedge aclk) p_d <= ptr_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ptr_reg <= '0;
            valid_reg <= '0;
            seen_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            item_reg <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    count_mem[ptr_reg[IW-1:0]] <= '0;
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == (IW+1)'(TABLE_DEPTH - 1)) begin
                        state_reg <= (item_reg.cmd == CMD_FRAME) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        res_reg <= '0;
                        ptr_reg <= '0;
                        hit_reg <= 1'b0;
                        unique case (s_data.cmd)
                            CMD_LOAD: begin
                                if ({1'b0, s_data.entry_index} < 7'(TABLE_DEPTH)) begin
                                    key_mem[s_data.entry_index[IW-1:0]] <= s_data.key_color;
                                    orig_mem[s_data.entry_index[IW-1:0]] <= s_data.orig_color;
                                    kind_mem[s_data.entry_index[IW-1:0]] <= s_data.entry_kind;
                                    count_mem[s_data.entry_index[IW-1:0]] <= '0;
                                    valid_reg[s_data.entry_index[IW-1:0]] <= 1'b1;
                                    seen_reg[s_data.entry_index[IW-1:0]] <= 1'b0;
                                end
                                state_reg <= S_OUT;
                            end
                            CMD_PIXEL: state_reg <= S_SRCH;
                            CMD_READ: state_reg <= S_RD;
                            default: begin
                                seen_reg <= '0;
                                col_reg <= '0;
                                row_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    // Read data arrives in the cycle after its address, so key_q belongs to ptr-1 (p_d).
                    if (ptr_reg != '0 && !hit_reg && valid_reg[p_d] &&
                        key_q == item_reg.pixel_color) begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= p_d;
                    end
                    if (ptr_reg == (IW+1)'(TABLE_DEPTH)) state_reg <= S_UPD;
                    else ptr_reg <= ptr_reg + 1'b1;
                end
                S_UPD: begin
                    // Check entry 0 again, read at the wrapped address, whose data arrives now, then settle.
                    if (!hit_reg && valid_reg[p_d] && key_q == item_reg.pixel_color) begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= p_d;
                    end else begin
                        res_reg.out_pixel <= item_reg.pixel_color;
                        if (item_reg.pixel_color == BLACK_PIXEL) begin
                            res_reg.pixel_status <= ST_BLACK;
                            state_reg <= S_DIV;
                        end else if (!hit_reg) begin
                            res_reg.pixel_status <= ST_UNKNOWN;
                            state_reg <= S_DIV;
                        end else begin
                            res_reg.pixel_status <= ST_RESTORED;
                            state_reg <= S_DIV;
                            hit_reg <= 1'b1;
                            ptr_reg <= '0;
                        end
                    end
                end
                S_DIV: begin
                    if (item_reg.cmd == CMD_PIXEL) begin
                        // rd_addr is hit_idx here; memory outputs hold the hit entry.
                        if (res_reg.pixel_status == ST_RESTORED) begin
                            res_reg.out_pixel <= orig_q;
                            if (count_q != {COUNT_BITS{1'b1}})
                                count_mem[hit_idx_reg] <= count_q + 1'b1;
                            if (!seen_reg[hit_idx_reg]) begin
                                seen_reg[hit_idx_reg] <= 1'b1;
                                box_mem[hit_idx_reg] <= {col_reg, row_reg, col_reg, row_reg};
                            end else begin
                                box_mem[hit_idx_reg] <= {
                                    (col_reg < bmnc) ? col_reg : bmnc,
                                    (row_reg < bmnr) ? row_reg : bmnr,
                                    (col_reg > bmxc) ? col_reg : bmxc,
                                    (row_reg > bmxr) ? row_reg : bmxr};
                            end
                        end
                        if ({1'b0, col_reg} >= w_eff - 1'b1) begin
                            if ({1'b0, row_reg} < h_eff - 1'b1) begin
                                col_reg <= '0;
                                row_reg <= row_reg + 1'b1;
                            end
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                        state_reg <= S_OUT;
                    end else if (div_done) begin
                        if (idx_in && valid_reg[item_reg.entry_index[IW-1:0]]) begin
                            res_reg.area_fraction <= frac;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_RD: begin
                    if (idx_in && valid_reg[item_reg.entry_index[IW-1:0]]) begin
                        res_reg.entry_seen <= seen_reg[item_reg.entry_index[IW-1:0]];
                        res_reg.kind_out <= kind_q;
                        res_reg.pixel_count <= count_q;
                        if (seen_reg[item_reg.entry_index[IW-1:0]]) begin
                            res_reg.min_col <= 12'(bmnc);
                            res_reg.min_row <= 12'(bmnr);
                            res_reg.max_col <= 12'(bmxc);
                            res_reg.max_row <= 12'(bmxr);
                        end
                    end
                    state_reg <= S_DIV;
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== verif/tb.sv =====
// Testbench for the mask color restore core: directed and random commands against a predictor.
`timescale 1ns / 1ps

module tb;
    import mcrbs_pkg::*;

    localparam int DEPTH = 32;
    localparam int DIMB  = 12;
    localparam int LIMIT = 2000000;

    class stats_scoreboard;
        logic [31:0] keys [DEPTH];
        logic [31:0] origs [DEPTH];
        logic        kinds [DEPTH];
        bit          valid [DEPTH];
        int unsigned counts [DEPTH];
        int unsigned bmin_c [DEPTH];
        int unsigned bmin_r [DEPTH];
        int unsigned bmax_c [DEPTH];
        int unsigned bmax_r [DEPTH];
        bit          seen [DEPTH];
        int unsigned col, row, width, height;
        out_item_t   pending [$];
        int          errors;
        int          checked;

        function new();
            width = 640;
            height = 480;
            errors = 0;
            checked = 0;
            col = 0;
            row = 0;
            for (int i = 0; i < DEPTH; i++) begin
                valid[i] = 0;
                counts[i] = 0;
                seen[i] = 0;
            end
        endfunction

        function int unsigned clamp(int unsigned v);
            if (v == 0) return 1;
            if (v > (1 << DIMB)) return 1 << DIMB;
            return v;
        endfunction

        function void set_size(int unsigned w, int unsigned h);
            width = w;
            height = h;
        endfunction

        function void note_input(in_item_t it);
            out_item_t r;
            int hit;
            int unsigned w, h;
            longint unsigned total, frac;
            r = '0;
            case (it.cmd)
                CMD_LOAD: begin
                    if (it.entry_index < DEPTH) begin
                        keys[it.entry_index] = it.key_color;
                        origs[it.entry_index] = it.orig_color;
                        kinds[it.entry_index] = it.entry_kind;
                        valid[it.entry_index] = 1;
                        counts[it.entry_index] = 0;
                        seen[it.entry_index] = 0;
                    end
                end
                CMD_PIXEL: begin
                    r.out_pixel = it.pixel_color;
                    r.pixel_status = ST_BLACK;
                    if (it.pixel_color != BLACK_PIXEL) begin
                        r.pixel_status = ST_UNKNOWN;
                        hit = -1;
                        for (int i = 0; i < DEPTH; i++)
                            if (hit < 0 && valid[i] && keys[i] == it.pixel_color) hit = i;
                        if (hit >= 0) begin
                            r.out_pixel = origs[hit];
                            r.pixel_status = ST_RESTORED;
                            if (counts[hit] < 32'h1FF_FFFF) counts[hit]++;
                            if (!seen[hit]) begin
                                seen[hit] = 1;
                                bmin_c[hit] = col;
                                bmax_c[hit] = col;
                                bmin_r[hit] = row;
                                bmax_r[hit] = row;
                            end else begin
                                if (col < bmin_c[hit]) bmin_c[hit] = col;
                                if (col > bmax_c[hit]) bmax_c[hit] = col;
                                if (row < bmin_r[hit]) bmin_r[hit] = row;
                                if (row > bmax_r[hit]) bmax_r[hit] = row;
                            end
                        end
                    end
                    w = clamp(width);
                    h = clamp(height);
                    if (!(col >= w - 1 && row >= h - 1)) begin
                        if (col >= w - 1) begin
                            col = 0;
                            row = (row + 1) & ((1 << DIMB) - 1);
                        end else begin
                            col = (col + 1) & ((1 << DIMB) - 1);
                        end
                    end
                end
                CMD_READ: begin
                    if (it.entry_index < DEPTH && valid[it.entry_index]) begin
                        r.entry_seen = seen[it.entry_index];
                        r.kind_out = kinds[it.entry_index];
                        r.pixel_count = 25'(counts[it.entry_index]);
                        if (seen[it.entry_index]) begin
                            r.min_col = 12'(bmin_c[it.entry_index]);
                            r.min_row = 12'(bmin_r[it.entry_index]);
                            r.max_col = 12'(bmax_c[it.entry_index]);
                            r.max_row = 12'(bmax_r[it.entry_index]);
                        end
                        total = longint'(clamp(width)) * clamp(height);
                        frac = ((longint'(counts[it.entry_index]) << 16) + (total >> 1)) / total;
                        if (frac > 65536) frac = 65536;
                        r.area_fraction = 17'(frac);
                    end
                end
                default: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        counts[i] = 0;
                        seen[i] = 0;
                    end
                    col = 0;
                    row = 0;
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.out_pixel !== exp_r.out_pixel)
                report("out_pixel", exp_r.out_pixel, got.out_pixel);
            if (got.pixel_status !== exp_r.pixel_status)
                report("pixel_status", 32'(exp_r.pixel_status), 32'(got.pixel_status));
            if (got.entry_seen !== exp_r.entry_seen)
                report("entry_seen", 32'(exp_r.entry_seen), 32'(got.entry_seen));
            if (got.kind_out !== exp_r.kind_out)
                report("kind_out", 32'(exp_r.kind_out), 32'(got.kind_out));
            if (got.pixel_count !== exp_r.pixel_count)
                report("pixel_count", 32'(exp_r.pixel_count), 32'(got.pixel_count));
            if (got.min_col !== exp_r.min_col)
                report("min_col", 32'(exp_r.min_col), 32'(got.min_col));
            if (got.min_row !== exp_r.min_row)
                report("min_row", 32'(exp_r.min_row), 32'(got.min_row));
            if (got.max_col !== exp_r.max_col)
                report("max_col", 32'(exp_r.max_col), 32'(got.max_col));
            if (got.max_row !== exp_r.max_row)
                report("max_row", 32'(exp_r.max_row), 32'(got.max_row));
            if (got.area_fraction !== exp_r.area_fraction)
                report("area_fraction", 32'(exp_r.area_fraction), 32'(got.area_fraction));
        endfunction

        function void report(string field, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s expected %h actual %h", $time, field, e, a);
            errors++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stats_scoreboard board;
    logic [31:0] palette [8];
    int  cycles;
    bit  hold_off;
    int  sent;

    mask_color_restore_bbox_stats_core dut (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    initial begin : sink
        int gap;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (!m_ready || m_valid) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                if (gap > 0 && $urandom_range(0, 1)) begin
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(posedge aclk);
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_item(in_item_t it, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_input(it);
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_size(w & 13'h1FFF, h & 13'h1FFF);
    endtask

    function automatic in_item_t make(logic [1:0] c, logic [5:0] idx, logic [31:0] k,
                                      logic [31:0] o, logic kd, logic [31:0] p);
        in_item_t it;
        it.cmd = c;
        it.entry_index = idx;
        it.key_color = k;
        it.orig_color = o;
        it.entry_kind = kd;
        it.pixel_color = p;
        return it;
    endfunction

    function automatic in_item_t random_item();
        int pick;
        logic [31:0] pix;
        pick = $urandom_range(0, 99);
        pix = palette[3'($urandom_range(0, 7))];
        if (pick < 5)
            return make(CMD_LOAD, 6'($urandom_range(0, 63)), palette[3'($urandom_range(0, 7))],
                        $urandom, 1'($urandom), $urandom);
        if (pick < 75) begin
            if ($urandom_range(0, 9) == 0) pix = $urandom;
            else if ($urandom_range(0, 9) == 0) pix = BLACK_PIXEL;
            return make(CMD_PIXEL, 6'($urandom), $urandom, $urandom, 1'($urandom), pix);
        end
        if (pick < 95)
            return make(CMD_READ, 6'(($urandom_range(0, 7) == 0) ? $urandom_range(32, 63)
                        : $urandom_range(0, 9)), $urandom, $urandom, 1'($urandom), $urandom);
        return make(CMD_FRAME, 6'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
    endfunction

    initial begin
        board = new();
        sent = 0;
        hold_off = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < 8; i++) palette[i] = $urandom;
        palette[7] = BLACK_PIXEL;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        set_frame(4, 3);
        send_item(make(CMD_LOAD, 0, palette[0], 32'h1111_1111, 1'b0, 0), 1);
        send_item(make(CMD_LOAD, 1, palette[0], 32'h2222_2222, 1'b1, 0), 1);
        send_item(make(CMD_LOAD, 2, BLACK_PIXEL, 32'h3333_3333, 1'b1, 0), 0);
        send_item(make(CMD_LOAD, 31, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0), 0);
        send_item(make(CMD_LOAD, 63, 32'h0, 32'hFFFF_FFFF, 1'b1, 0), 0);
        send_item(make(CMD_LOAD, 3, palette[1], 32'hFFFF_FFFF, 1'b1, 0), 0);
        send_item(make(CMD_READ, 3, 0, 0, 0, 0), 0);
        send_item(make(CMD_PIXEL, 0, 0, 0, 0, BLACK_PIXEL), 0);
        send_item(make(CMD_PIXEL, 0, 0, 0, 0, palette[0]), 1);
        send_item(make(CMD_PIXEL, 0, 0, 0, 0, 32'h0), 0);
        send_item(make(CMD_PIXEL, 0, 0, 0, 0, 32'hFFFF_FFFF), 0);
        for (int i = 0; i < 12; i++)
            send_item(make(CMD_PIXEL, 0, 0, 0, 0, palette[i % 2]), 0);
        send_item(make(CMD_READ, 0, 0, 0, 0, 0), 0);
        send_item(make(CMD_READ, 1, 0, 0, 0, 0), 0);
        send_item(make(CMD_READ, 3, 0, 0, 0, 0), 0);
        send_item(make(CMD_READ, 31, 0, 0, 0, 0), 0);
        send_item(make(CMD_READ, 40, 0, 0, 0, 0), 0);
        send_item(make(CMD_READ, 63, 0, 0, 0, 0), 0);
        send_item(make(CMD_FRAME, 0, 0, 0, 0, 0), 0);
        send_item(make(CMD_READ, 0, 0, 0, 0, 0), 0);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_frame(0, 0);
                1: set_frame(1, 4096);
                2: set_frame(8191, 2);
                3: set_frame(7, 5);
                4: set_frame(4096, 4096);
                default: set_frame(3, 1);
            endcase
            for (int i = 0; i < 8; i++)
                send_item(make(CMD_LOAD, 6'(i), palette[i], $urandom, 1'($urandom), 0), 1);
            if (phase == 2) begin
                hold_off = 1;
                fork
                    begin
                        repeat (400) @(posedge aclk);
                        hold_off = 0;
                    end
                    for (int i = 0; i < 20; i++) send_item(random_item(), 0);
                join
            end
            for (int i = 0; i < 110; i++) send_item(random_item(), $urandom_range(0, 3) != 0);
            for (int i = 0; i < 8; i++) send_item(make(CMD_READ, 6'(i), 0, 0, 0, 0), 1);
        end

        drain();
        $display("Sent %0d commands over 7 frame sizes including zero, one and oversized;",
                 sent);
        $display("checked %0d results with loads, pixels, stats reads and frame restarts.",
                 board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d expectations left over", board.pending.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== mask_color_restore_bbox_stats_core.f =====
sv/mcrbs_pkg.sv
sv/mcrbs_divider.sv
sv/mask_color_restore_bbox_stats_core.sv
verif/tb.sv
